@@ rtl/pofc_pkg.sv @@
// Shared types, constants and layout decoders for the pixel format compositor.
`default_nettype none

package pofc_pkg;

    localparam logic [15:0] UNIT2     = 16'd65025;
    localparam logic [7:0]  FULL      = 8'd255;
    localparam int          NUM_LANES = 3;

    // pixel_format codes
    localparam logic [3:0] FMT_ARGB32    = 4'd0;
    localparam logic [3:0] FMT_ARGB32_PM = 4'd1;
    localparam logic [3:0] FMT_XRGB32    = 4'd2;
    localparam logic [3:0] FMT_RGBA32    = 4'd3;
    localparam logic [3:0] FMT_RGBA32_PM = 4'd4;
    localparam logic [3:0] FMT_ABGR32    = 4'd5;
    localparam logic [3:0] FMT_ABGR32_PM = 4'd6;
    localparam logic [3:0] FMT_XBGR32    = 4'd7;
    localparam logic [3:0] FMT_BGRA32    = 4'd8;
    localparam logic [3:0] FMT_BGRA32_PM = 4'd9;
    localparam logic [3:0] FMT_RGB24     = 4'd10;
    localparam logic [3:0] FMT_BGR24     = 4'd11;
    localparam logic [3:0] FMT_RGBX32    = 4'd12;
    localparam logic [3:0] FMT_BGRX32    = 4'd13;

    // source byte selectors; BYTE_ONE stands for a constant 255
    localparam logic [2:0] BYTE_0   = 3'd0;
    localparam logic [2:0] BYTE_1   = 3'd1;
    localparam logic [2:0] BYTE_2   = 3'd2;
    localparam logic [2:0] BYTE_3   = 3'd3;
    localparam logic [2:0] BYTE_ONE = 3'd4;

    // output byte contents
    localparam logic [2:0] SEL_ZERO  = 3'd0;
    localparam logic [2:0] SEL_RED   = 3'd1;
    localparam logic [2:0] SEL_GREEN = 3'd2;
    localparam logic [2:0] SEL_BLUE  = 3'd3;
    localparam logic [2:0] SEL_ALPHA = 3'd4;

    // alpha slot of an input layout map
    localparam int LANE_ALPHA = 3;

    typedef enum logic [1:0] {
        KIND_STRAIGHT = 2'd0,
        KIND_PREMUL   = 2'd1,
        KIND_OPAQUE   = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    // [0] red, [1] green, [2] blue, [3] alpha (input), or bytes 0..3 (output)
    typedef logic [3:0][2:0] sel4_t;

    typedef struct packed {
        logic [24:0] n;
        logic [15:0] d;
    } div_lane_t;

    typedef div_lane_t [NUM_LANES-1:0] div_lanes_t;
    typedef logic [NUM_LANES-1:0][7:0] lane_bytes_t;

    function automatic kind_t fmt_kind(input logic [3:0] fmt);
        kind_t k;
        unique case (fmt) inside
            FMT_ARGB32, FMT_RGBA32, FMT_ABGR32, FMT_BGRA32:
                k = KIND_STRAIGHT;
            FMT_ARGB32_PM, FMT_RGBA32_PM, FMT_ABGR32_PM, FMT_BGRA32_PM:
                k = KIND_PREMUL;
            FMT_XRGB32, FMT_XBGR32, FMT_RGB24, FMT_BGR24, FMT_RGBX32, FMT_BGRX32:
                k = KIND_OPAQUE;
            default:
                k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic sel4_t in_map(input logic [3:0] fmt);
        sel4_t s;
        unique case (fmt) inside
            FMT_ARGB32, FMT_ARGB32_PM: s = {BYTE_0, BYTE_3, BYTE_2, BYTE_1};
            FMT_XRGB32:                s = {BYTE_ONE, BYTE_3, BYTE_2, BYTE_1};
            FMT_RGBA32, FMT_RGBA32_PM: s = {BYTE_3, BYTE_2, BYTE_1, BYTE_0};
            FMT_ABGR32, FMT_ABGR32_PM: s = {BYTE_0, BYTE_1, BYTE_2, BYTE_3};
            FMT_XBGR32:                s = {BYTE_ONE, BYTE_1, BYTE_2, BYTE_3};
            FMT_BGRA32, FMT_BGRA32_PM: s = {BYTE_3, BYTE_0, BYTE_1, BYTE_2};
            FMT_RGB24, FMT_RGBX32:     s = {BYTE_ONE, BYTE_2, BYTE_1, BYTE_0};
            FMT_BGR24, FMT_BGRX32:     s = {BYTE_ONE, BYTE_0, BYTE_1, BYTE_2};
            default:                   s = {BYTE_ONE, BYTE_ONE, BYTE_ONE, BYTE_ONE};
        endcase
        return s;
    endfunction

    function automatic sel4_t out_map(input logic [3:0] fmt);
        sel4_t s;
        unique case (fmt) inside
            FMT_ARGB32, FMT_ARGB32_PM: s = {SEL_BLUE, SEL_GREEN, SEL_RED, SEL_ALPHA};
            FMT_XRGB32:                s = {SEL_BLUE, SEL_GREEN, SEL_RED, SEL_ZERO};
            FMT_RGBA32, FMT_RGBA32_PM: s = {SEL_ALPHA, SEL_BLUE, SEL_GREEN, SEL_RED};
            FMT_ABGR32, FMT_ABGR32_PM: s = {SEL_RED, SEL_GREEN, SEL_BLUE, SEL_ALPHA};
            FMT_XBGR32:                s = {SEL_RED, SEL_GREEN, SEL_BLUE, SEL_ZERO};
            FMT_BGRA32, FMT_BGRA32_PM: s = {SEL_ALPHA, SEL_RED, SEL_GREEN, SEL_BLUE};
            FMT_RGB24, FMT_RGBX32:     s = {SEL_ZERO, SEL_BLUE, SEL_GREEN, SEL_RED};
            FMT_BGR24, FMT_BGRX32:     s = {SEL_ZERO, SEL_RED, SEL_GREEN, SEL_BLUE};
            default:                   s = {SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO};
        endcase
        return s;
    endfunction

    function automatic logic [7:0] byte_pick(input logic [31:0] word, input logic [2:0] sel);
        logic [7:0] b;
        unique case (sel)
            BYTE_0:  b = word[7:0];
            BYTE_1:  b = word[15:8];
            BYTE_2:  b = word[23:16];
            BYTE_3:  b = word[31:24];
            default: b = FULL;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pofc_front.sv @@
// Front end: unpack the destination word, form dividend and divisor per lane and the alpha byte.
`default_nettype none

module pofc_front
    import pofc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [3:0]  fmt,
    input  wire logic [31:0] dest_pixel,
    input  wire logic [7:0]  src_red,
    input  wire logic [7:0]  src_green,
    input  wire logic [7:0]  src_blue,
    input  wire logic [7:0]  src_alpha,
    output logic             out_valid,
    output logic [3:0]       out_fmt,
    output div_lanes_t       out_lanes,
    output logic [7:0]       out_alpha
);

    // stage 1: byte select and the 8x8 products
    logic              s1_valid_reg;
    logic [3:0]        s1_fmt_reg;
    logic [2:0][7:0]   s1_src_reg;
    logic [2:0][15:0]  s1_prod_reg;
    logic [7:0]        s1_mul_reg;
    logic [15:0]       s1_alpha_reg;

    logic [2:0][7:0]   s1_src_next;
    logic [2:0][15:0]  s1_prod_next;
    logic [7:0]        s1_mul_next;
    logic [15:0]       s1_alpha_next;

    always_comb
    begin
        kind_t      kind;
        sel4_t      sel;
        logic [7:0] inv;
        logic [7:0] da;
        logic [7:0] dc;
        kind = fmt_kind(fmt);
        sel  = in_map(fmt);
        inv  = FULL - src_alpha;
        da   = byte_pick(dest_pixel, sel[LANE_ALPHA]);
        s1_src_next = {src_blue, src_green, src_red};
        for (int i = 0; i < 3; i++)
        begin
            dc = byte_pick(dest_pixel, sel[i]);
            s1_prod_next[i] = {8'd0, inv} * {8'd0, dc};
        end
        s1_mul_next   = (kind == KIND_STRAIGHT) ? da : FULL;
        s1_alpha_next = {8'd0, src_alpha} * {8'd0, FULL} + {8'd0, inv} * {8'd0, da};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_fmt_reg   <= fmt;
        s1_src_reg   <= s1_src_next;
        s1_prod_reg  <= s1_prod_next;
        s1_mul_reg   <= s1_mul_next;
        s1_alpha_reg <= s1_alpha_next;
    end

    // stage 2: colour numerators in units of 1/255^3, divisors per lane, result alpha
    logic       s2_valid_reg;
    logic [3:0] s2_fmt_reg;
    div_lanes_t s2_lanes_reg;
    logic [7:0] s2_alpha_reg;
    div_lanes_t s2_lanes_next;
    logic [7:0] s2_alpha_next;

    always_comb
    begin
        kind_t kind;
        kind = fmt_kind(s1_fmt_reg);
        for (int i = 0; i < 3; i++)
        begin
            s2_lanes_next[i].n = {17'd0, s1_src_reg[i]} * {9'd0, UNIT2}
                               + {9'd0, s1_prod_reg[i]} * {17'd0, s1_mul_reg};
            s2_lanes_next[i].d = (kind == KIND_PREMUL) ? UNIT2 : s1_alpha_reg;
        end
        // floor(x / 255) by reciprocal, holds for x up to 65025
        s2_alpha_next = 8'((s1_alpha_reg + {8'd0, s1_alpha_reg[15:8]} + 16'd1) >> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_fmt_reg   <= s1_fmt_reg;
        s2_lanes_reg <= s2_lanes_next;
        s2_alpha_reg <= s2_alpha_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_fmt   = s2_fmt_reg;
    assign out_lanes = s2_lanes_reg;
    assign out_alpha = s2_alpha_reg;

endmodule

`default_nettype wire

@@ rtl/pofc_div.sv @@
// Three-lane restoring divider, one quotient bit per stage, saturating at 255.
`default_nettype none

module pofc_div
    import pofc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [3:0]  in_fmt,
    input  wire div_lanes_t  in_lanes,
    input  wire logic [7:0]  in_alpha,
    output logic             out_valid,
    output logic [3:0]       out_fmt,
    output lane_bytes_t      out_q,
    output logic [NUM_LANES-1:0] out_sat,
    output logic [7:0]       out_alpha
);

    localparam int QBITS = 8;

    logic                          valid_reg [0:QBITS];
    logic [3:0]                    fmt_reg   [0:QBITS];
    logic [7:0]                    alpha_reg [0:QBITS];
    logic [NUM_LANES-1:0][23:0]    rem_reg   [0:QBITS];
    logic [NUM_LANES-1:0][15:0]    div_reg   [0:QBITS];
    logic [NUM_LANES-1:0][7:0]     quo_reg   [0:QBITS];
    logic [NUM_LANES-1:0]          sat_reg   [0:QBITS];
    logic [NUM_LANES-1:0]          zero_reg  [0:QBITS];

    logic [NUM_LANES-1:0][23:0]    rem_next  [1:QBITS];
    logic [NUM_LANES-1:0][7:0]     quo_next  [1:QBITS];
    logic [NUM_LANES-1:0]          sat_next;
    logic [NUM_LANES-1:0]          zero_next;

    // entry stage: catch the saturating and zero-divisor cases up front
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            zero_next[i] = (in_lanes[i].d == 16'd0);
            sat_next[i]  = (in_lanes[i].n >= {1'b0, in_lanes[i].d, 8'd0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fmt_reg[0]   <= in_fmt;
        alpha_reg[0] <= in_alpha;
        sat_reg[0]   <= sat_next;
        zero_reg[0]  <= zero_next;
        quo_reg[0]   <= '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rem_reg[0][i] <= in_lanes[i].n[23:0];
            div_reg[0][i] <= in_lanes[i].d;
        end
    end

    for (genvar j = 0; j < QBITS; j++)
    begin : g_stage
        localparam int K = QBITS - 1 - j;

        always_comb
        begin
            logic [23:0] dsh;
            logic [24:0] trial;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                dsh   = {8'd0, div_reg[j][i]} << K;
                trial = {1'b0, rem_reg[j][i]} - {1'b0, dsh};
                // keep the remainder when the trial subtraction went negative
                rem_next[j+1][i] = trial[24] ? rem_reg[j][i] : trial[23:0];
                quo_next[j+1][i] = {quo_reg[j][i][6:0], ~trial[24]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else
                valid_reg[j+1] <= valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            fmt_reg[j+1]   <= fmt_reg[j];
            alpha_reg[j+1] <= alpha_reg[j];
            rem_reg[j+1]   <= rem_next[j+1];
            div_reg[j+1]   <= div_reg[j];
            quo_reg[j+1]   <= quo_next[j+1];
            sat_reg[j+1]   <= sat_reg[j];
            zero_reg[j+1]  <= zero_reg[j];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (zero_reg[QBITS][i])
                out_q[i] = 8'd0;
            else if (sat_reg[QBITS][i])
                out_q[i] = FULL;
            else
                out_q[i] = quo_reg[QBITS][i];
            out_sat[i] = sat_reg[QBITS][i] & ~zero_reg[QBITS][i];
        end
    end

    assign out_valid = valid_reg[QBITS];
    assign out_fmt   = fmt_reg[QBITS];
    assign out_alpha = alpha_reg[QBITS];

endmodule

`default_nettype wire

@@ rtl/pixel_format_over_composite_core.sv @@
// Top level: source-over compositing onto a destination word in one of fourteen layouts.
// Throughput: one word per cycle; busy is held low and a new word may enter every cycle.
// Depth: two front stages, the divider entry stage, eight quotient stages and the pack stage.
// Reset (rst_n low, asynchronous) clears all stage valid bits and sets pixel_format to 0.
// Results cannot be stalled: each word is shown on the result ports for one cycle only.
`default_nettype none

module pixel_format_over_composite_core
    import pofc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_format_wr,
    input  wire logic [3:0]  pixel_format_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] dest_pixel,
    input  wire logic [7:0]  src_red,
    input  wire logic [7:0]  src_green,
    input  wire logic [7:0]  src_blue,
    input  wire logic [7:0]  src_alpha,
    output logic             done,
    output logic [31:0]      out_pixel,
    output logic             clamped
);

    logic [3:0] pixel_format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_format_reg <= FMT_ARGB32;
        else if (pixel_format_wr)
            pixel_format_reg <= pixel_format_data;
    end

    assign busy = 1'b0;

    logic       fr_valid;
    logic [3:0] fr_fmt;
    div_lanes_t fr_lanes;
    logic [7:0] fr_alpha;

    pofc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start & ~busy),
        .fmt        (pixel_format_reg),
        .dest_pixel (dest_pixel),
        .src_red    (src_red),
        .src_green  (src_green),
        .src_blue   (src_blue),
        .src_alpha  (src_alpha),
        .out_valid  (fr_valid),
        .out_fmt    (fr_fmt),
        .out_lanes  (fr_lanes),
        .out_alpha  (fr_alpha)
    );

    logic                  dv_valid;
    logic [3:0]            dv_fmt;
    lane_bytes_t           dv_q;
    logic [NUM_LANES-1:0]  dv_sat;
    logic [7:0]            dv_alpha;

    pofc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_fmt    (fr_fmt),
        .in_lanes  (fr_lanes),
        .in_alpha  (fr_alpha),
        .out_valid (dv_valid),
        .out_fmt   (dv_fmt),
        .out_q     (dv_q),
        .out_sat   (dv_sat),
        .out_alpha (dv_alpha)
    );

    // pack stage
    logic        done_reg;
    logic [31:0] pixel_reg;
    logic        clamp_reg;
    logic [31:0] pixel_next;
    logic        clamp_next;

    always_comb
    begin
        kind_t kind;
        sel4_t sel;
        kind = fmt_kind(dv_fmt);
        sel  = out_map(dv_fmt);
        for (int b = 0; b < 4; b++)
        begin
            unique case (sel[b])
                SEL_RED:   pixel_next[8*b +: 8] = dv_q[0];
                SEL_GREEN: pixel_next[8*b +: 8] = dv_q[1];
                SEL_BLUE:  pixel_next[8*b +: 8] = dv_q[2];
                SEL_ALPHA: pixel_next[8*b +: 8] = dv_alpha;
                default:   pixel_next[8*b +: 8] = 8'd0;
            endcase
        end
        // premultiplied channels saturate silently
        clamp_next = ((kind == KIND_STRAIGHT) || (kind == KIND_OPAQUE)) && (|dv_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        clamp_reg <= clamp_next & dv_valid;
    end

    assign done      = done_reg;
    assign out_pixel = pixel_reg;
    assign clamped   = clamp_reg;

    // every accepted word gives exactly one result
    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##12 done)
        else $error("accepted word did not complete after fixed latency");

    a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##12 !done)
        else $error("result strobe without a matching accepted word");

    a_clamp_done: assert property (@(posedge clk) disable iff (!rst_n)
        clamped |-> done)
        else $error("clamped raised outside a result cycle");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for the source-over compositor across all pixel layouts.

module tb_top;
    import pofc_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned DONE_LATENCY = 12;
    localparam int unsigned SETTLE       = DONE_LATENCY + 4;
    localparam int unsigned STALL_LIMIT  = 500;
    localparam int unsigned RANDOM_WORDS = 65;
    localparam int unsigned FEW_WORDS    = 15;
    localparam int unsigned NUM_DIRECTED = 6;
    localparam int unsigned NUM_PHASES   = 17;
    localparam logic [39:0] UNIT_SQ      = 40'd65025;

    // codes beyond the last layout
    localparam logic [3:0] FMT_RSVD_14 = 4'd14;
    localparam logic [3:0] FMT_RSVD_15 = 4'd15;

    // first four phases also carry the directed words
    localparam logic [0:NUM_PHASES-1][3:0] PHASE_ORDER = {
        FMT_ARGB32, FMT_BGRX32, FMT_RSVD_15, FMT_RGB24, FMT_RSVD_14,
        FMT_ARGB32_PM, FMT_XRGB32, FMT_RGBA32, FMT_RGBA32_PM, FMT_ABGR32,
        FMT_ABGR32_PM, FMT_XBGR32, FMT_BGRA32, FMT_BGRA32_PM, FMT_BGR24,
        FMT_RGBX32, FMT_ARGB32
    };

    typedef struct packed {
        logic [31:0] dest;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [3:0]  gap;
    } pixel_word_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        clamped;
    } over_result_t;

    logic        clk               = 1'b0;
    logic        rst_n             = 1'b0;
    logic        pixel_format_wr   = 1'b0;
    logic [3:0]  pixel_format_data = 4'd0;
    logic        start             = 1'b0;
    logic [31:0] dest_pixel        = 32'd0;
    logic [7:0]  src_red           = 8'd0;
    logic [7:0]  src_green         = 8'd0;
    logic [7:0]  src_blue          = 8'd0;
    logic [7:0]  src_alpha         = 8'd0;
    logic        busy;
    logic        done;
    logic [31:0] out_pixel;
    logic        clamped;

    pixel_word_t  words_to_send[$];
    over_result_t results_due[$];
    over_result_t due_result;
    pixel_word_t  staged_word;
    bit           staged_valid    = 1'b0;
    int unsigned  gap_left        = 0;
    logic [3:0]   active_format   = FMT_ARGB32;
    int unsigned  words_queued    = 0;
    int unsigned  words_taken     = 0;
    int unsigned  results_checked = 0;
    int unsigned  clamp_hits      = 0;
    int unsigned  mismatches      = 0;
    int unsigned  stall_cycles    = 0;

    pixel_format_over_composite_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixel_format_wr   (pixel_format_wr),
        .pixel_format_data (pixel_format_data),
        .start             (start),
        .busy              (busy),
        .dest_pixel        (dest_pixel),
        .src_red           (src_red),
        .src_green         (src_green),
        .src_blue          (src_blue),
        .src_alpha         (src_alpha),
        .done              (done),
        .out_pixel         (out_pixel),
        .clamped           (clamped)
    );

    function automatic over_result_t composite_over(
        input logic [3:0]  fmt,
        input logic [31:0] dest,
        input logic [7:0]  red,
        input logic [7:0]  green,
        input logic [7:0]  blue,
        input logic [7:0]  alpha
    );
        kind_t           kind;
        logic [3:0][2:0] pick;
        logic [3:0][2:0] place;
        logic [4:0][7:0] lanes;
        logic [4:0][7:0] chan;
        logic [2:0][7:0] src;
        logic [39:0]     inv, da, m, a_sum, c_sum, sc, dc, q;
        over_result_t    res;
        int              i;
        res   = '0;
        pick  = '0;
        place = '0;
        case (fmt)
            FMT_ARGB32, FMT_RGBA32, FMT_ABGR32, FMT_BGRA32:
                kind = KIND_STRAIGHT;
            FMT_ARGB32_PM, FMT_RGBA32_PM, FMT_ABGR32_PM, FMT_BGRA32_PM:
                kind = KIND_PREMUL;
            FMT_XRGB32, FMT_XBGR32, FMT_RGB24, FMT_BGR24, FMT_RGBX32, FMT_BGRX32:
                kind = KIND_OPAQUE;
            default:
                kind = KIND_NONE;
        endcase
        if (kind == KIND_NONE)
            return res;
        // pick: [0] red .. [3] alpha source byte; place: content of output byte 0..3
        case (fmt)
            FMT_ARGB32, FMT_ARGB32_PM:
            begin
                pick  = {BYTE_0, BYTE_3, BYTE_2, BYTE_1};
                place = {SEL_BLUE, SEL_GREEN, SEL_RED, SEL_ALPHA};
            end
            FMT_XRGB32:
            begin
                pick  = {BYTE_ONE, BYTE_3, BYTE_2, BYTE_1};
                place = {SEL_BLUE, SEL_GREEN, SEL_RED, SEL_ZERO};
            end
            FMT_RGBA32, FMT_RGBA32_PM:
            begin
                pick  = {BYTE_3, BYTE_2, BYTE_1, BYTE_0};
                place = {SEL_ALPHA, SEL_BLUE, SEL_GREEN, SEL_RED};
            end
            FMT_ABGR32, FMT_ABGR32_PM:
            begin
                pick  = {BYTE_0, BYTE_1, BYTE_2, BYTE_3};
                place = {SEL_RED, SEL_GREEN, SEL_BLUE, SEL_ALPHA};
            end
            FMT_XBGR32:
            begin
                pick  = {BYTE_ONE, BYTE_1, BYTE_2, BYTE_3};
                place = {SEL_RED, SEL_GREEN, SEL_BLUE, SEL_ZERO};
            end
            FMT_BGRA32, FMT_BGRA32_PM:
            begin
                pick  = {BYTE_3, BYTE_0, BYTE_1, BYTE_2};
                place = {SEL_ALPHA, SEL_RED, SEL_GREEN, SEL_BLUE};
            end
            FMT_RGB24, FMT_RGBX32:
            begin
                pick  = {BYTE_ONE, BYTE_2, BYTE_1, BYTE_0};
                place = {SEL_ZERO, SEL_BLUE, SEL_GREEN, SEL_RED};
            end
            default:
            begin
                pick  = {BYTE_ONE, BYTE_0, BYTE_1, BYTE_2};
                place = {SEL_ZERO, SEL_RED, SEL_GREEN, SEL_BLUE};
            end
        endcase
        lanes = {8'hff, dest};
        src   = {blue, green, red};
        da    = 40'(lanes[pick[3]]);
        m     = (kind == KIND_STRAIGHT) ? da : 40'd255;
        inv   = 40'd255 - 40'(alpha);
        a_sum = 40'(alpha) * UNIT_SQ + inv * da * 40'd255;
        chan  = '0;
        for (i = 0; i < 3; i++)
        begin
            sc    = 40'(src[i]);
            dc    = 40'(lanes[pick[i]]);
            c_sum = sc * UNIT_SQ + inv * dc * m;
            if (kind == KIND_PREMUL)
            begin
                q = c_sum / UNIT_SQ;
                if (q > 40'd255)
                    q = 40'd255;
            end
            else if (a_sum == 40'd0)
                q = 40'd0;
            else
            begin
                q = (40'd255 * c_sum) / a_sum;
                if (q > 40'd255)
                begin
                    q           = 40'd255;
                    res.clamped = 1'b1;
                end
            end
            chan[i + 1] = q[7:0];
        end
        q       = a_sum / UNIT_SQ;
        chan[4] = q[7:0];
        for (i = 0; i < 4; i++)
            res.pixel[8*i +: 8] = chan[place[i]];
        return res;
    endfunction

    // 0: back to back, 1: uniform gaps, 2: mostly back to back with odd holes
    function automatic logic [3:0] draw_gap(input int unsigned style);
        logic [3:0] g;
        case (style)
            0:       g = 4'd0;
            1:       g = 4'($urandom_range(0, 13));
            default: g = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 13)) : 4'd0;
        endcase
        return g;
    endfunction

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // present queued words, predicting each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            staged_valid = 1'b0;
            gap_left     = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                results_due.push_back(composite_over(active_format, dest_pixel,
                                                     src_red, src_green, src_blue, src_alpha));
                words_taken++;
            end
            if (!start || !busy)
            begin
                if (!staged_valid && words_to_send.size() != 0)
                begin
                    staged_word  = words_to_send.pop_front();
                    gap_left     = staged_word.gap;
                    staged_valid = 1'b1;
                end
                if (staged_valid && gap_left == 0)
                begin
                    dest_pixel   <= staged_word.dest;
                    src_red      <= staged_word.red;
                    src_green    <= staged_word.green;
                    src_blue     <= staged_word.blue;
                    src_alpha    <= staged_word.alpha;
                    start        <= 1'b1;
                    staged_valid = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                    if (staged_valid)
                        gap_left--;
                end
            end
        end
    end

    // compare each result strobe with the oldest prediction; watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got pixel %h clamped %b",
                             $time, out_pixel, clamped);
                    mismatches++;
                end
                else
                begin
                    due_result = results_due.pop_front();
                    results_checked++;
                    if (clamped === 1'b1)
                        clamp_hits++;
                    if (out_pixel !== due_result.pixel)
                    begin
                        $display("%0t: out_pixel mismatch, expected %h, got %h",
                                 $time, due_result.pixel, out_pixel);
                        mismatches++;
                    end
                    if (clamped !== due_result.clamped)
                    begin
                        $display("%0t: clamped mismatch, expected %b, got %b",
                                 $time, due_result.clamped, clamped);
                        mismatches++;
                    end
                end
            end
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        pixel_word_t w;
        int unsigned p, k, n, style, lane;
        logic [3:0]  fmt;
        logic [7:0]  sa;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (p = 0; p < NUM_PHASES; p++)
        begin
            fmt   = PHASE_ORDER[p];
            style = p % 3;
            // the first phase runs on the reset value
            if (p != 0)
            begin
                @(posedge clk);
                pixel_format_wr   <= 1'b1;
                pixel_format_data <= fmt;
                @(posedge clk);
                pixel_format_wr   <= 1'b0;
                active_format = fmt;
            end
            if (p < 4)
            begin
                for (k = 0; k < NUM_DIRECTED; k++)
                begin
                    case (k)
                        // all zero: zero result alpha in straight layouts
                        0: w = {32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0};
                        1: w = {32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff, 4'd0};
                        // transparent source over transparent dest, colour left in source
                        2: w = {32'hffff_ff00, 8'h80, 8'h80, 8'h80, 8'h00, 4'd0};
                        // source colour above its alpha: saturate
                        3: w = {32'h0000_0000, 8'hff, 8'h80, 8'h01, 8'h10, 4'd0};
                        // top byte set, source transparent: 24-bit must drop it
                        4: w = {32'ha55a_c33c, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0};
                        default: w = {32'h8040_2010, 8'h7f, 8'h3f, 8'h1f, 8'h80, 4'd0};
                    endcase
                    w.gap = draw_gap(style);
                    words_to_send.push_back(w);
                    words_queued++;
                end
            end
            n = (fmt == FMT_RSVD_14 || fmt == FMT_RSVD_15) ? FEW_WORDS : RANDOM_WORDS;
            for (k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       sa = 8'h00;
                    1:       sa = 8'hff;
                    default: sa = 8'($urandom_range(0, 255));
                endcase
                w.dest  = $urandom;
                w.alpha = sa;
                // push a byte to an alpha extreme now and then
                if ($urandom_range(0, 2) == 0)
                begin
                    lane = $urandom_range(0, 3);
                    w.dest[8*lane +: 8] = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
                end
                // mostly well-formed premultiplied colour, the rest unconstrained
                if ($urandom_range(0, 4) != 0)
                begin
                    w.red   = 8'($urandom_range(0, sa));
                    w.green = 8'($urandom_range(0, sa));
                    w.blue  = 8'($urandom_range(0, sa));
                end
                else
                begin
                    w.red   = 8'($urandom_range(0, 255));
                    w.green = 8'($urandom_range(0, 255));
                    w.blue  = 8'($urandom_range(0, 255));
                end
                w.gap = draw_gap(style);
                words_to_send.push_back(w);
                words_queued++;
            end
            // hold until every result of this phase is back, then let the pipe empty
            while (words_taken != words_queued || results_due.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
        if (results_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            mismatches++;
        end
        $display("Sent %0d words over %0d format phases, including both unused codes.",
                 words_taken, NUM_PHASES);
        $display("Checked %0d results, %0d with saturation; %0d mismatches.",
                 results_checked, clamp_hits, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
